[src/e2q_pkg.sv]
// ============================================================================
// e2q_pkg - shared types and constants of the Euler to quaternion converter
// Holds the CORDIC word formats, the per-axis cell payload and the
// arctangent table used by every rotation cell.
// ============================================================================
`default_nettype none

package e2q_pkg;

    localparam int TRIG_ITERATIONS = 16;
    localparam int ATAN_ENTRIES    = 24;
    localparam int CORDIC_STAGES   = (TRIG_ITERATIONS < ATAN_ENTRIES) ?
                                     TRIG_ITERATIONS : ATAN_ENTRIES;
    localparam int SHIFT_W         = $clog2(ATAN_ENTRIES);

    localparam int ANGLE_W = 16;
    localparam int QUAT_W  = 16;
    localparam int TRIG_W  = 32;
    localparam int ACC_W   = 34;
    localparam int PROD_W  = 64;

    localparam int NUM_AXES  = 3;
    localparam int AXIS_ROLL  = 0;
    localparam int AXIS_PITCH = 1;
    localparam int AXIS_YAW   = 2;

    localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 32'sd652032874;
    localparam int Q14_ONE = 16384;

    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [ACC_W-1:0]  z;
    } t_rot;

    typedef t_rot [NUM_AXES-1:0] t_axes;

    // Arctangent of 2^-i in units of pi/2^31.
    function automatic logic signed [ACC_W-1:0] atan_unit(input logic [SHIFT_W-1:0] idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[src/e2q_cell.sv]
// ============================================================================
// e2q_cell - one CORDIC rotation step for all three axes
// Applies micro-rotation number i_shift to roll, pitch and yaw at once and
// registers the result with its own valid bit, handing it on to the next cell.
// ============================================================================
`default_nettype none

module e2q_cell
    import e2q_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [SHIFT_W-1:0] i_shift,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire t_axes              i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_axes                   o_data
);

    logic  r_valid;
    t_axes r_data;
    t_axes n_data;
    logic  w_load;
    logic signed [ACC_W-1:0] w_atan;

    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign w_atan  = atan_unit(i_shift);

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            // The sign of the residual angle picks the rotation direction.
            if (!i_data[a].z[ACC_W-1]) begin
                n_data[a].x = i_data[a].x - (i_data[a].y >>> i_shift);
                n_data[a].y = i_data[a].y + (i_data[a].x >>> i_shift);
                n_data[a].z = i_data[a].z - w_atan;
            end else begin
                n_data[a].x = i_data[a].x + (i_data[a].y >>> i_shift);
                n_data[a].y = i_data[a].y - (i_data[a].x >>> i_shift);
                n_data[a].z = i_data[a].z + w_atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

[src/e2q_quat.sv]
// ============================================================================
// e2q_quat - quaternion product stages
// Takes the half-angle sines and cosines and forms w, x, y and z over three
// registered stages: pair products, cross products, then sum, round and clamp.
// ============================================================================
`default_nettype none

module e2q_quat
    import e2q_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire t_axes                    i_data,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed [QUAT_W-1:0]      o_quat_w,
    output logic signed [QUAT_W-1:0]      o_quat_x,
    output logic signed [QUAT_W-1:0]      o_quat_y,
    output logic signed [QUAT_W-1:0]      o_quat_z
);

    localparam logic signed [PROD_W-1:0] RND30 = 64'sd536870912;
    localparam logic signed [PROD_W-1:0] RND46 = 64'sd35184372088832;

    // Round a Q60 sum to Q14 and clamp to plus or minus one.
    function automatic logic signed [QUAT_W-1:0] to_q14(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] s;
        logic signed [QUAT_W-1:0] q;
        s = (v + RND46) >>> 46;
        if (s > 64'sd16384) begin
            q = 16'sd16384;
        end else if (s < -64'sd16384) begin
            q = -16'sd16384;
        end else begin
            q = s[QUAT_W-1:0];
        end
        return q;
    endfunction

    // Stage A: pitch and yaw pair products, roll carried alongside.
    logic r_va;
    logic w_load_a;
    logic signed [TRIG_W-1:0] r_cr, r_sr, r_cpcy, r_spsy, r_cpsy, r_spcy;
    logic signed [TRIG_W-1:0] n_cpcy, n_spsy, n_cpsy, n_spcy;

    // Stage B: the eight Q60 cross products.
    logic r_vb;
    logic w_load_b;
    logic signed [PROD_W-1:0] r_p_w0, r_p_w1, r_p_x0, r_p_x1;
    logic signed [PROD_W-1:0] r_p_y0, r_p_y1, r_p_z0, r_p_z1;

    // Stage C: output register.
    logic r_vc;
    logic w_load_c;
    logic signed [QUAT_W-1:0] r_qw, r_qx, r_qy, r_qz;

    assign w_load_c = !r_vc || i_ready;
    assign w_load_b = !r_vb || w_load_c;
    assign w_load_a = !r_va || w_load_b;
    assign o_ready  = w_load_a;

    always_comb begin
        logic signed [PROD_W-1:0] p0, p1, p2, p3;
        p0 = i_data[AXIS_PITCH].x * i_data[AXIS_YAW].x;
        p1 = i_data[AXIS_PITCH].y * i_data[AXIS_YAW].y;
        p2 = i_data[AXIS_PITCH].x * i_data[AXIS_YAW].y;
        p3 = i_data[AXIS_PITCH].y * i_data[AXIS_YAW].x;
        p0 = (p0 + RND30) >>> 30;
        p1 = (p1 + RND30) >>> 30;
        p2 = (p2 + RND30) >>> 30;
        p3 = (p3 + RND30) >>> 30;
        n_cpcy = p0[TRIG_W-1:0];
        n_spsy = p1[TRIG_W-1:0];
        n_cpsy = p2[TRIG_W-1:0];
        n_spcy = p3[TRIG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_load_a) begin
                r_va <= i_valid;
            end
            if (w_load_b) begin
                r_vb <= r_va;
            end
            if (w_load_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_a && i_valid) begin
            r_cr   <= i_data[AXIS_ROLL].x;
            r_sr   <= i_data[AXIS_ROLL].y;
            r_cpcy <= n_cpcy;
            r_spsy <= n_spsy;
            r_cpsy <= n_cpsy;
            r_spcy <= n_spcy;
        end
        if (w_load_b && r_va) begin
            r_p_w0 <= r_cr * r_cpcy;
            r_p_w1 <= r_sr * r_spsy;
            r_p_x0 <= r_sr * r_cpcy;
            r_p_x1 <= r_cr * r_spsy;
            r_p_y0 <= r_cr * r_spcy;
            r_p_y1 <= r_sr * r_cpsy;
            r_p_z0 <= r_cr * r_cpsy;
            r_p_z1 <= r_sr * r_spcy;
        end
        if (w_load_c && r_vb) begin
            r_qw <= to_q14(r_p_w0 + r_p_w1);
            r_qx <= to_q14(r_p_x0 - r_p_x1);
            r_qy <= to_q14(r_p_y0 + r_p_y1);
            r_qz <= to_q14(r_p_z0 - r_p_z1);
        end
    end

    assign o_valid  = r_vc;
    assign o_quat_w = r_qw;
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;

endmodule

`default_nettype wire

[src/euler_to_quaternion.sv]
// ============================================================================
// euler_to_quaternion - ZYX Euler angles to unit quaternion
// A chain of CORDIC cells gives the half-angle sines and cosines of roll,
// pitch and yaw; a short product pipeline forms the Q2.14 quaternion.
// ============================================================================
// Usage:
// The input channel (i_valid, o_ready) takes one request of three signed
// 16-bit binary angles, where the full range spans -pi to pi. The output
// channel (o_valid, i_ready) returns one request carrying w, x, y and z in
// Q2.14, clamped to plus or minus 16384.
// From acceptance to o_valid a request passes one register per CORDIC
// cell (16 cells, one per rotation step) and three product stages.
// Throughput is one request per cycle; every cell and stage holds its own
// valid bit, so a new request enters each cycle while the pipeline flows.
// When the receiver stalls, the output register holds its request and the
// stages behind it keep filling until every one is occupied; only then does
// o_ready fall. No request is dropped or duplicated.
// Reset is synchronous and active low; it empties every stage, and o_ready
// is high in the first cycle after it. The block keeps no state between
// requests.
// ============================================================================
`default_nettype none

module euler_to_quaternion
    import e2q_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic signed [ANGLE_W-1:0] i_roll_angle,
    input  wire logic signed [ANGLE_W-1:0] i_pitch_angle,
    input  wire logic signed [ANGLE_W-1:0] i_yaw_angle,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed [QUAT_W-1:0]      o_quat_w,
    output logic signed [QUAT_W-1:0]      o_quat_x,
    output logic signed [QUAT_W-1:0]      o_quat_y,
    output logic signed [QUAT_W-1:0]      o_quat_z
);

    t_axes w_chain_data  [CORDIC_STAGES+1];
    logic  w_chain_valid [CORDIC_STAGES+1];
    logic  w_chain_ready [CORDIC_STAGES+1];
    logic signed [ANGLE_W-1:0] w_angle [NUM_AXES];

    assign w_angle[AXIS_ROLL]  = i_roll_angle;
    assign w_angle[AXIS_PITCH] = i_pitch_angle;
    assign w_angle[AXIS_YAW]   = i_yaw_angle;

    // Start vector carries the gain compensation; the accumulator holds the
    // half angle in units of pi/2^31.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_chain_data[0][a].x = CORDIC_X0;
            w_chain_data[0][a].y = '0;
            w_chain_data[0][a].z = {{(ACC_W-ANGLE_W-15){w_angle[a][ANGLE_W-1]}},
                                    w_angle[a], 15'b0};
        end
    end

    assign w_chain_valid[0] = i_valid;
    assign o_ready          = w_chain_ready[0];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        e2q_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (SHIFT_W'(k)),
            .i_valid (w_chain_valid[k]),
            .o_ready (w_chain_ready[k]),
            .i_data  (w_chain_data[k]),
            .o_valid (w_chain_valid[k+1]),
            .i_ready (w_chain_ready[k+1]),
            .o_data  (w_chain_data[k+1])
        );
    end

    e2q_quat u_quat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_chain_valid[CORDIC_STAGES]),
        .o_ready  (w_chain_ready[CORDIC_STAGES]),
        .i_data   (w_chain_data[CORDIC_STAGES]),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_quat_w (o_quat_w),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z)
    );

endmodule

`default_nettype wire

[src/e2q_checker.sv]
// ============================================================================
// e2q_checker - port-level checks of the Euler to quaternion converter
// Watches the top-level ports for reset behaviour, output hold, result
// range and input readiness when the output side is empty.
// ============================================================================
`default_nettype none

module e2q_checker
    import e2q_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_ready,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic signed [QUAT_W-1:0]  o_quat_w,
    input wire logic signed [QUAT_W-1:0]  o_quat_x,
    input wire logic signed [QUAT_W-1:0]  o_quat_y,
    input wire logic signed [QUAT_W-1:0]  o_quat_z
);

    // The pipeline is empty straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output request present after reset");

    // A stalled result request stays until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_quat_w) && $stable(o_quat_x)
            && $stable(o_quat_y) && $stable(o_quat_z))
        else $error("stalled output request changed");

    // Every component is clamped to plus or minus one.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_quat_w <= 16'sd16384 && o_quat_w >= -16'sd16384
            && o_quat_x <= 16'sd16384 && o_quat_x >= -16'sd16384
            && o_quat_y <= 16'sd16384 && o_quat_y >= -16'sd16384
            && o_quat_z <= 16'sd16384 && o_quat_z >= -16'sd16384)
        else $error("quaternion component out of range");

    // With no result waiting, nothing can block the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input not ready while output side is empty");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (.*);

`default_nettype wire

[tb/euler_to_quaternion_checker.sv]
// ============================================================================
// euler_to_quaternion_checker - result predictor and comparator
// Watches both request channels of the Euler to quaternion converter. Each
// accepted angle triple is converted by a fixed-point CORDIC model and queued.
// Each returned quaternion is compared field by field with the oldest entry.
// ============================================================================
`default_nettype none

module euler_to_quaternion_checker
    import e2q_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_ready,
    input  wire logic signed [ANGLE_W-1:0] i_roll,
    input  wire logic signed [ANGLE_W-1:0] i_pitch,
    input  wire logic signed [ANGLE_W-1:0] i_yaw,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_ready,
    input  wire logic signed [QUAT_W-1:0]  i_quat_w,
    input  wire logic signed [QUAT_W-1:0]  i_quat_x,
    input  wire logic signed [QUAT_W-1:0]  i_quat_y,
    input  wire logic signed [QUAT_W-1:0]  i_quat_z,
    output int                             o_pending,
    output int                             o_fail_count,
    output int                             o_result_count
);

    localparam int PRINT_CAP = 30;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
        logic signed [QUAT_W-1:0]  w;
        logic signed [QUAT_W-1:0]  x;
        logic signed [QUAT_W-1:0]  y;
        logic signed [QUAT_W-1:0]  z;
    } t_conversion;

    t_conversion quat_expected [$];
    t_conversion oldest;

    // Rotation step of the angle accumulator, atan(2^-i) in units of pi/2^31.
    function automatic longint arctan_step(input int i);
        longint a;
        case (i)
            0:       a = 536870912;
            1:       a = 316933406;
            2:       a = 167458907;
            3:       a = 85004756;
            4:       a = 42667331;
            5:       a = 21354465;
            6:       a = 10679838;
            7:       a = 5340245;
            8:       a = 2670163;
            9:       a = 1335087;
            10:      a = 667544;
            11:      a = 333772;
            12:      a = 166886;
            13:      a = 83443;
            14:      a = 41722;
            15:      a = 20861;
            16:      a = 10430;
            17:      a = 5215;
            18:      a = 2608;
            19:      a = 1304;
            20:      a = 652;
            21:      a = 326;
            22:      a = 163;
            23:      a = 81;
            default: a = 0;
        endcase
        return a;
    endfunction

    // Cosine and sine in Q30 of half the binary angle. Shifts on longint are
    // arithmetic, so they round towards minus infinity.
    function automatic void half_angle_trig(input logic signed [ANGLE_W-1:0] angle,
                                            output longint cos_q30,
                                            output longint sin_q30);
        longint cx;
        longint cy;
        longint acc;
        longint dx;
        longint dy;
        int     steps;
        int     i;
        cx    = CORDIC_X0;
        cy    = 0;
        acc   = longint'(angle) * 32768;
        steps = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
        for (i = 0; i < steps; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (acc >= 0) begin
                cx  = cx - dx;
                cy  = cy + dy;
                acc = acc - arctan_step(i);
            end else begin
                cx  = cx + dx;
                cy  = cy - dy;
                acc = acc + arctan_step(i);
            end
        end
        cos_q30 = cx;
        sin_q30 = cy;
    endfunction

    function automatic longint round_down_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [QUAT_W-1:0] q60_to_q14(input longint v);
        longint r;
        r = round_down_shift(v, 46);
        if (r > Q14_ONE)
            r = Q14_ONE;
        if (r < -Q14_ONE)
            r = -Q14_ONE;
        return QUAT_W'(r);
    endfunction

    function automatic t_conversion predict_quaternion(input logic signed [ANGLE_W-1:0] roll,
                                                       input logic signed [ANGLE_W-1:0] pitch,
                                                       input logic signed [ANGLE_W-1:0] yaw);
        longint      cr;
        longint      sr;
        longint      cp;
        longint      sp;
        longint      cyw;
        longint      syw;
        longint      cp_cy;
        longint      sp_sy;
        longint      cp_sy;
        longint      sp_cy;
        t_conversion c;
        half_angle_trig(roll, cr, sr);
        half_angle_trig(pitch, cp, sp);
        half_angle_trig(yaw, cyw, syw);
        cp_cy = round_down_shift(cp * cyw, 30);
        sp_sy = round_down_shift(sp * syw, 30);
        cp_sy = round_down_shift(cp * syw, 30);
        sp_cy = round_down_shift(sp * cyw, 30);
        c.roll  = roll;
        c.pitch = pitch;
        c.yaw   = yaw;
        c.w     = q60_to_q14(cr * cp_cy + sr * sp_sy);
        c.x     = q60_to_q14(sr * cp_cy - cr * sp_sy);
        c.y     = q60_to_q14(cr * sp_cy + sr * cp_sy);
        c.z     = q60_to_q14(cr * cp_sy - sr * sp_cy);
        return c;
    endfunction

    // Only the first few failures are printed so that a broken build cannot
    // flood the log; every one is still counted.
    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic compare_field(input string name, input logic signed [QUAT_W-1:0] got,
                                 input logic signed [QUAT_W-1:0] want, input t_conversion c);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d (roll %0d pitch %0d yaw %0d)",
                                      name, got, want, c.roll, c.pitch, c.yaw));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quat_expected.delete();
            o_pending <= 0;
        end else begin
            // The result side is looked at first: a request accepted at this
            // edge cannot be the cause of a result leaving at the same edge.
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (quat_expected.size() == 0) begin
                    report_mismatch($sformatf("result with nothing outstanding: %0d %0d %0d %0d",
                                              i_quat_w, i_quat_x, i_quat_y, i_quat_z));
                end else begin
                    oldest = quat_expected.pop_front();
                    compare_field("w", i_quat_w, oldest.w, oldest);
                    compare_field("x", i_quat_x, oldest.x, oldest);
                    compare_field("y", i_quat_y, oldest.y, oldest);
                    compare_field("z", i_quat_z, oldest.z, oldest);
                end
            end
            if (i_in_valid && i_in_ready)
                quat_expected.push_back(predict_quaternion(i_roll, i_pitch, i_yaw));
            o_pending <= quat_expected.size();
        end
    end

endmodule

`default_nettype wire

[tb/euler_to_quaternion_tb.sv]
// ============================================================================
// euler_to_quaternion_tb - testbench top of the Euler to quaternion converter
// Drives directed and random angle triples into the converter with random
// gaps and output stalls; the checker beside it predicts and compares every
// quaternion, and this module gives the verdict.
// ============================================================================
`default_nettype none

module euler_to_quaternion_tb;

    import e2q_pkg::*;

    localparam int N_DIRECTED   = 19;
    localparam int N_RANDOM     = 950;
    localparam int CALM_TAIL    = 120;
    localparam int SEGMENT      = 64;
    localparam int DRAIN_TAIL   = 40;
    localparam int CYCLE_LIMIT  = 100000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic signed [ANGLE_W-1:0] i_roll_angle;
    logic signed [ANGLE_W-1:0] i_pitch_angle;
    logic signed [ANGLE_W-1:0] i_yaw_angle;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [QUAT_W-1:0]  o_quat_w;
    logic signed [QUAT_W-1:0]  o_quat_x;
    logic signed [QUAT_W-1:0]  o_quat_y;
    logic signed [QUAT_W-1:0]  o_quat_z;

    int  pending;
    int  fail_count;
    int  result_count;
    int  requests_sent;
    int  cycle_count;
    bit  send_gaps_on;
    bit  sink_stalls_on;

    euler_to_quaternion dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_roll_angle  (i_roll_angle),
        .i_pitch_angle (i_pitch_angle),
        .i_yaw_angle   (i_yaw_angle),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_quat_w      (o_quat_w),
        .o_quat_x      (o_quat_x),
        .o_quat_y      (o_quat_y),
        .o_quat_z      (o_quat_z)
    );

    euler_to_quaternion_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_roll         (i_roll_angle),
        .i_pitch        (i_pitch_angle),
        .i_yaw          (i_yaw_angle),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_quat_w       (o_quat_w),
        .i_quat_x       (o_quat_x),
        .i_quat_y       (o_quat_y),
        .i_quat_z       (o_quat_z),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, pending);
            $display("euler_to_quaternion_tb NOT OK");
            $finish;
        end
    end

    // Extremes of each axis, the half-turn case where the half-angle cosine
    // is near zero, quarter turns, alternating bit patterns and mixed signs.
    function automatic logic [3*ANGLE_W-1:0] directed_triple(input int n);
        logic [3*ANGLE_W-1:0] t;
        case (n)
            0:       t = {16'h0000, 16'h0000, 16'h0000};
            1:       t = {16'h7FFF, 16'h0000, 16'h0000};
            2:       t = {16'h8000, 16'h0000, 16'h0000};
            3:       t = {16'h0000, 16'h7FFF, 16'h0000};
            4:       t = {16'h0000, 16'h8000, 16'h0000};
            5:       t = {16'h0000, 16'h0000, 16'h7FFF};
            6:       t = {16'h0000, 16'h0000, 16'h8000};
            7:       t = {16'h4000, 16'h0000, 16'h0000};
            8:       t = {16'h0000, 16'h4000, 16'h0000};
            9:       t = {16'h0000, 16'h0000, 16'h4000};
            10:      t = {16'hC000, 16'hC000, 16'hC000};
            11:      t = {16'h7FFF, 16'h7FFF, 16'h7FFF};
            12:      t = {16'h8000, 16'h8000, 16'h8000};
            13:      t = {16'h0001, 16'hFFFF, 16'h0001};
            14:      t = {16'hFFFF, 16'h0001, 16'hFFFF};
            15:      t = {16'h5555, 16'hAAAA, 16'h5555};
            16:      t = {16'hAAAA, 16'h5555, 16'hAAAA};
            17:      t = {16'h2000, 16'h2000, 16'h2000};
            default: t = {16'h8000, 16'h4000, 16'h7FFF};
        endcase
        return t;
    endfunction

    // Mostly uniform angles, with a share of extremes, tiny angles and
    // angles just either side of a quarter or half turn.
    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        logic signed [ANGLE_W-1:0] a;
        logic signed [ANGLE_W-1:0] base;
        int                        kind;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            a = ANGLE_W'($urandom);
        end else if (kind == 6) begin
            case ($urandom_range(0, 6))
                0:       a = 16'sh8000;
                1:       a = 16'sh7FFF;
                2:       a = 16'shC000;
                3:       a = 16'sh4000;
                4:       a = 16'sh0000;
                5:       a = 16'shFFFF;
                default: a = 16'sh0001;
            endcase
        end else if (kind == 7) begin
            a = ANGLE_W'(int'($urandom_range(0, 64)) - 32);
        end else begin
            case ($urandom_range(0, 3))
                0:       base = 16'sh4000;
                1:       base = 16'shC000;
                2:       base = 16'sh7FFF;
                default: base = 16'sh8000;
            endcase
            a = base + ANGLE_W'(int'($urandom_range(0, 16)) - 8);
        end
        return a;
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_angles(input logic signed [ANGLE_W-1:0] roll,
                               input logic signed [ANGLE_W-1:0] pitch,
                               input logic signed [ANGLE_W-1:0] yaw);
        i_valid       <= 1'b1;
        i_roll_angle  <= roll;
        i_pitch_angle <= pitch;
        i_yaw_angle   <= yaw;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic maybe_pause_input();
        if (send_gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge i_clk);
        end
    endtask

    // Holds the input off until the checker has nothing left outstanding.
    task automatic drain_results();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    // After each stall, i_ready is raised again before another stall can begin.
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (i_ready && sink_stalls_on && $urandom_range(0, 4) == 0) begin
                i_ready    <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [3*ANGLE_W-1:0] t;
        int                   n;
        requests_sent  = 0;
        send_gaps_on   = 1'b1;
        sink_stalls_on = 1'b1;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_roll_angle  <= '0;
        i_pitch_angle <= '0;
        i_yaw_angle   <= '0;
        repeat (11)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < N_DIRECTED; n++) begin
            t = directed_triple(n);
            send_angles(t[47:32], t[31:16], t[15:0]);
            maybe_pause_input();
        end
        drain_results();

        for (n = 0; n < N_RANDOM; n++) begin
            if (n % SEGMENT == 0) begin
                send_gaps_on   = ($urandom_range(0, 2) != 0);
                sink_stalls_on = ($urandom_range(0, 2) != 0);
            end
            if (n == N_RANDOM - CALM_TAIL) begin
                send_gaps_on   = 1'b0;
                sink_stalls_on = 1'b0;
            end
            if (n == N_RANDOM / 2)
                drain_results();
            send_angles(pick_angle(), pick_angle(), pick_angle());
            maybe_pause_input();
        end

        drain_results();
        repeat (DRAIN_TAIL)
            @(posedge i_clk);

        $display("%0d angle triples sent (%0d directed, rest random), %0d quaternions returned,",
                 requests_sent, N_DIRECTED, result_count);
        $display("with random input gaps and output stalls; %0d mismatches", fail_count);
        if (fail_count == 0)
            $display("euler_to_quaternion_tb OK");
        else
            $display("euler_to_quaternion_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
